FILE: src/ordered_value_list_engine_defines.svh
// Assertion macros shared by the ordered value list engine.
// Depends on a clk and an active-low rst_n in the module that uses them.
`ifndef ORDERED_VALUE_LIST_ENGINE_DEFINES_SVH
`define ORDERED_VALUE_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define OVLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OVLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ovle_pkg.sv
// Shared types and constants of the ordered value list engine.
// No dependencies.
package ovle_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // Stream packing
  localparam int IN_ACTION_LO  = 0;
  localparam int IN_ITEM_LO    = IN_ACTION_LO + ACTION_W;
  localparam int IN_ANCHOR_LO  = IN_ITEM_LO + VALUE_W;
  localparam int IN_USED_W     = IN_ANCHOR_LO + VALUE_W;
  localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W    = STATUS_W + COUNT_W;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_PUSH   = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_REMOVE = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_INS_TAKE,
    S_LINK,
    S_RM_UNLINK,
    S_RM_FREE,
    S_DONE
  } seq_state_t;

  // Node store access strobes
  typedef struct packed {
    logic rd_en;
    logic val_we;
    logic link_we;
  } mem_ctl_t;

endpackage

FILE: src/ovle_node_store.sv
// Node pool: value memory and link memory, one read port and one write port each.
// Depends on ovle_pkg.
module ovle_node_store
  import ovle_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mem_ctl_t                   ctl,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  input  logic [$clog2(CAPACITY)-1:0] val_waddr,
  input  logic [VALUE_W-1:0]         val_wdata,
  input  logic [$clog2(CAPACITY)-1:0] link_waddr,
  input  logic [$clog2(CAPACITY)-1:0] link_wdata,
  output logic [VALUE_W-1:0]         val_q,
  output logic [$clog2(CAPACITY)-1:0] link_q
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [VALUE_W-1:0] val_mem [CAPACITY];
  logic [IDX_W-1:0]   link_mem [CAPACITY];

  logic [VALUE_W-1:0] val_q_r;
  logic [IDX_W-1:0]   link_q_r;

  // Entries at or above the high-water mark were never taken; their link
  // is the reset chain (next index, last wraps to zero).
  logic [CNT_W-1:0] hwm_r;
  logic [CNT_W-1:0] hwm_nxt;
  logic [CNT_W-1:0] rd_inc;
  logic             rd_fresh;
  logic [IDX_W-1:0] rd_dflt;
  logic             fresh_r;
  logic [IDX_W-1:0] dflt_r;

  assign rd_inc   = CNT_W'(rd_addr) + 1'b1;
  assign rd_fresh = (CNT_W'(rd_addr) >= hwm_r);
  assign rd_dflt  = (rd_inc == CNT_W'(CAPACITY)) ? '0 : IDX_W'(rd_inc);

  always_comb begin
    hwm_nxt = hwm_r;
    if (ctl.val_we && (CNT_W'(val_waddr) == hwm_r)) begin
      hwm_nxt = hwm_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwm_r <= '0;
    end else begin
      hwm_r <= hwm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (ctl.rd_en) begin
      val_q_r <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (ctl.rd_en) begin
      link_q_r <= link_mem[rd_addr];
      fresh_r  <= rd_fresh;
      dflt_r   <= rd_dflt;
    end
  end

  assign val_q  = val_q_r;
  assign link_q = fresh_r ? dflt_r : link_q_r;

endmodule

FILE: src/ovle_seq.sv
// Request sequencer: list pointers, chain walk, relinking and result register.
// Depends on ovle_pkg and the assertion macros header.
`include "ordered_value_list_engine_defines.svh"

module ovle_seq
  import ovle_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ACTION_W-1:0]         in_action,
  input  logic signed [VALUE_W-1:0]   in_item,
  input  logic signed [VALUE_W-1:0]   in_anchor,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [STATUS_W-1:0]         out_status,
  output logic [COUNT_W-1:0]          out_count,
  output mem_ctl_t                    mem_ctl,
  output logic [$clog2(CAPACITY)-1:0] rd_addr,
  output logic [$clog2(CAPACITY)-1:0] val_waddr,
  output logic [VALUE_W-1:0]          val_wdata,
  output logic [$clog2(CAPACITY)-1:0] link_waddr,
  output logic [$clog2(CAPACITY)-1:0] link_wdata,
  input  logic [VALUE_W-1:0]          val_q,
  input  logic [$clog2(CAPACITY)-1:0] link_q
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  seq_state_t state_r, state_nxt;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] at_r, at_nxt;
  logic [IDX_W-1:0] before_r, before_nxt;
  logic [IDX_W-1:0] link_at_r, link_at_nxt;
  action_t          op_r, op_nxt;
  status_t          status_r, status_nxt;
  logic [VALUE_W-1:0] item_r, item_nxt;
  logic [VALUE_W-1:0] target_r, target_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic             full;
  logic             cnt_zero;
  logic [CNT_W-1:0] k_inc;
  logic             hit;
  action_t          in_op;

  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign cnt_zero = (cnt_r == '0);
  assign k_inc    = k_r + 1'b1;
  assign hit      = (val_q == target_r);
  assign in_op    = action_t'(in_action);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_nxt       = free_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    k_nxt          = k_r;
    at_nxt         = at_r;
    before_nxt     = before_r;
    link_at_nxt    = link_at_r;
    op_nxt         = op_r;
    status_nxt     = status_r;
    item_nxt       = item_r;
    target_nxt     = target_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_ctl        = '0;
    rd_addr        = free_r;
    val_waddr      = free_r;
    val_wdata      = item_r;
    link_waddr     = free_r;
    link_wdata     = free_r;
    in_ready       = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          item_nxt   = in_item;
          target_nxt = (in_op == ACT_INSERT) ? in_anchor : in_item;
          status_nxt = STAT_OK;
          cur_nxt    = head_r;
          prev_nxt   = head_r;
          k_nxt      = '0;
          case (in_op)
            ACT_APPEND, ACT_PUSH: begin
              if (full) begin
                status_nxt = STAT_FULL;
                state_nxt  = S_DONE;
              end else begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = free_r;
                state_nxt     = S_LINK;
              end
            end
            ACT_INSERT: begin
              if (full) begin
                status_nxt = STAT_FULL;
                state_nxt  = S_DONE;
              end else if (cnt_zero) begin
                // no anchor can exist: append
                op_nxt        = ACT_APPEND;
                mem_ctl.rd_en = 1'b1;
                rd_addr       = free_r;
                state_nxt     = S_LINK;
              end else begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = head_r;
                state_nxt     = S_WALK;
              end
            end
            ACT_SEARCH, ACT_REMOVE: begin
              if (cnt_zero) begin
                status_nxt = STAT_MISS;
                state_nxt  = S_DONE;
              end else begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = head_r;
                state_nxt     = S_WALK;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // One node checked per cycle; the next read is issued from the link just returned.
      S_WALK: begin
        if (hit) begin
          at_nxt      = cur_r;
          before_nxt  = prev_r;
          link_at_nxt = link_q;
          case (op_r)
            ACT_INSERT: state_nxt = S_INS_TAKE;
            ACT_REMOVE: state_nxt = S_RM_UNLINK;
            default:    state_nxt = S_DONE;
          endcase
        end else if (k_inc == cnt_r) begin
          if (op_r == ACT_INSERT) begin
            op_nxt        = ACT_APPEND;
            mem_ctl.rd_en = 1'b1;
            rd_addr       = free_r;
            state_nxt     = S_LINK;
          end else begin
            status_nxt = STAT_MISS;
            state_nxt  = S_DONE;
          end
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = link_q;
          prev_nxt      = cur_r;
          cur_nxt       = link_q;
          k_nxt         = k_inc;
        end
      end

      // Fetch the free-list successor and hook the new node behind the anchor.
      S_INS_TAKE: begin
        mem_ctl.rd_en   = 1'b1;
        rd_addr         = free_r;
        mem_ctl.link_we = 1'b1;
        link_waddr      = at_r;
        link_wdata      = free_r;
        state_nxt       = S_LINK;
      end

      // link_q holds the link of the node being taken from the free list.
      S_LINK: begin
        free_nxt       = link_q;
        mem_ctl.val_we = 1'b1;
        val_waddr      = free_r;
        val_wdata      = item_r;
        cnt_nxt        = cnt_r + 1'b1;
        case (op_r)
          ACT_APPEND: begin
            if (cnt_zero) begin
              head_nxt = free_r;
            end else begin
              mem_ctl.link_we = 1'b1;
              link_waddr      = tail_r;
              link_wdata      = free_r;
            end
            tail_nxt = free_r;
          end
          ACT_PUSH: begin
            mem_ctl.link_we = 1'b1;
            link_waddr      = free_r;
            link_wdata      = head_r;
            if (cnt_zero) begin
              tail_nxt = free_r;
            end
            head_nxt = free_r;
          end
          ACT_INSERT: begin
            mem_ctl.link_we = 1'b1;
            link_waddr      = free_r;
            link_wdata      = link_at_r;
            if (at_r == tail_r) begin
              tail_nxt = free_r;
            end
          end
          default: begin
          end
        endcase
        state_nxt = S_DONE;
      end

      S_RM_UNLINK: begin
        if (at_r == head_r) begin
          head_nxt = link_at_r;
        end else begin
          mem_ctl.link_we = 1'b1;
          link_waddr      = before_r;
          link_wdata      = link_at_r;
          if (at_r == tail_r) begin
            tail_nxt = before_r;
          end
        end
        state_nxt = S_RM_FREE;
      end

      // Put the removed node at the head of the free list.
      S_RM_FREE: begin
        mem_ctl.link_we = 1'b1;
        link_waddr      = at_r;
        link_wdata      = free_r;
        free_nxt        = at_r;
        cnt_nxt         = cnt_r - 1'b1;
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = COUNT_W'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    k_r          <= k_nxt;
    at_r         <= at_nxt;
    before_r     <= before_nxt;
    link_at_r    <= link_at_nxt;
    op_r         <= op_nxt;
    status_r     <= status_nxt;
    item_r       <= item_nxt;
    target_r     <= target_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  `OVLE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CAPACITY), "count above capacity")
  `OVLE_ASSERT_IMP(a_walk_bound, state_r == S_WALK, k_r < cnt_r, "walk past list end")
  `OVLE_ASSERT_IMP(a_take_not_full, state_r == S_LINK, !full, "node taken from full pool")
  `OVLE_ASSERT_NXT(a_cnt_hold, state_r != S_LINK && state_r != S_RM_FREE, $stable(cnt_r),
    "count changed outside link or free step")
  `OVLE_ASSERT_NXT(a_done_load, state_r == S_DONE && (!out_valid_r || out_ready),
    out_valid_r && state_r == S_IDLE, "result not loaded on completion")

endmodule

FILE: src/ordered_value_list_engine.sv
// Append and push go from acceptance through the link step to the result register; a search
// walks to the matching node, insert-after adds the take and link steps, remove adds the unlink
// and free steps, and insert-after with an absent anchor walks the whole list, then appends.
// Throughput: one request at a time, the next accepted once the result is
// registered; the walk reads one node per cycle from the node memories.
// Reset: synchronous active low, list empty at once, no memory sweep.
module ordered_value_list_engine
  import ovle_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // action[2:0], item_value[34:3], anchor_value[66:35], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[1:0], entry_count[10:2], zero fill above
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = $clog2(CAPACITY);

  mem_ctl_t            mem_ctl;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    val_waddr;
  logic [VALUE_W-1:0]  val_wdata;
  logic [IDX_W-1:0]    link_waddr;
  logic [IDX_W-1:0]    link_wdata;
  logic [VALUE_W-1:0]  val_q;
  logic [IDX_W-1:0]    link_q;

  logic [ACTION_W-1:0]       in_action;
  logic signed [VALUE_W-1:0] in_item;
  logic signed [VALUE_W-1:0] in_anchor;
  logic [STATUS_W-1:0]       out_status;
  logic [COUNT_W-1:0]        out_count;

  assign in_action = in_tdata[IN_ACTION_LO +: ACTION_W];
  assign in_item   = in_tdata[IN_ITEM_LO +: VALUE_W];
  assign in_anchor = in_tdata[IN_ANCHOR_LO +: VALUE_W];

  assign out_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_count, out_status};

  ovle_node_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mem_ctl),
    .rd_addr    (rd_addr),
    .val_waddr  (val_waddr),
    .val_wdata  (val_wdata),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .val_q      (val_q),
    .link_q     (link_q)
  );

  ovle_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_action),
    .in_item    (in_item),
    .in_anchor  (in_anchor),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_count  (out_count),
    .mem_ctl    (mem_ctl),
    .rd_addr    (rd_addr),
    .val_waddr  (val_waddr),
    .val_wdata  (val_wdata),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .val_q      (val_q),
    .link_q     (link_q)
  );

endmodule
